[rtl/core/ppmc_pkg.sv]
// Package for the PPM P6 to BGRX stream converter.
// Holds shared constants, phase and status codes, and the result bundle type.
// No dependencies.
package ppmc_pkg;

  // Width of the decimal accumulator and of the image dimension counters.
  localparam int unsigned DIM_BITS = 24;
  localparam logic [DIM_BITS-1:0] DIM_MAX = '1;
  localparam logic [DIM_BITS-1:0] MAXVAL_REQ = {{(DIM_BITS-8){1'b0}}, 8'hFF};
  localparam logic [DIM_BITS-1:0] DIM_ONE = {{(DIM_BITS-1){1'b0}}, 1'b1};

  // Stream characters
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Output header magic
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_X = 8'h58;

  typedef enum logic [5:0] {
    PH_MAGIC   = 6'b000001,
    PH_WIDTH   = 6'b000010,
    PH_HEIGHT  = 6'b000100,
    PH_MAXVAL  = 6'b001000,
    PH_PIXELS  = 6'b010000,
    PH_STOPPED = 6'b100000
  } phase_e;

  typedef enum logic [2:0] {
    ST_BUSY       = 3'd0,
    ST_DONE       = 3'd1,
    ST_BAD_MAGIC  = 3'd2,
    ST_BAD_WIDTH  = 3'd3,
    ST_BAD_HEIGHT = 3'd4,
    ST_BAD_MAXVAL = 3'd5,
    ST_EMPTY_TOK  = 3'd6,
    ST_EARLY_END  = 3'd7
  } status_e;

  // All results caused by one input byte: up to four, sent one per cycle while the receiver is ready.
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      count;     // 0..4
    logic            has_byte;
    status_e         status;
  } bundle_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_eol(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

[rtl/core/ppmc_if.sv]
// Stream interfaces for the PPM P6 to BGRX converter: input bytes and results.
// valid/ready handshake; a request moves when both are high. No dependencies.
interface ppmc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface ppmc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       last_of_run;
  logic [2:0] status;

  modport source (output valid, output out_byte, output has_byte, output last_of_run,
                  output status, input ready);
  modport sink   (input valid, input out_byte, input has_byte, input last_of_run,
                  input status, output ready);
endinterface

[rtl/core/ppmc_parser.sv]
// Parser state and next-state logic of the PPM P6 to BGRX converter.
// One byte per step_i; emits the bundle of results for that byte. Uses ppmc_pkg.
module ppmc_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              eos_i,
  output ppmc_pkg::bundle_t bundle_o
);
  import ppmc_pkg::*;

  phase_e              phase_q, phase_d;
  status_e             status_q, status_d;
  logic                cmt_q, cmt_d;
  logic                skip_q, skip_d;
  logic [1:0]          tok_q, tok_d;
  logic                magic_ok_q, magic_ok_d;
  logic                neg_q, neg_d;
  logic                stop_q, stop_d;
  logic [DIM_BITS-1:0] acc_q, acc_d;
  logic [DIM_BITS-1:0] width_q, width_d;
  logic [DIM_BITS-1:0] col_q, col_d;    // pixels left in the current row
  logic [DIM_BITS-1:0] row_q, row_d;    // rows left, current one included
  logic [1:0]          bip_q, bip_d;
  logic [15:0]         held_q, held_d;

  logic [DIM_BITS+3:0] acc_mul;
  logic                positive;
  bundle_t             bnd;

  // acc*10 + digit, shifts and adds only
  assign acc_mul = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
                 + {{(DIM_BITS-4){1'b0}}, byte_i - CH_0};
  assign positive = !neg_q && (acc_q != '0);

  always_comb begin
    phase_d    = phase_q;
    status_d   = status_q;
    cmt_d      = cmt_q;
    skip_d     = skip_q;
    tok_d      = tok_q;
    magic_ok_d = magic_ok_q;
    neg_d      = neg_q;
    stop_d     = stop_q;
    acc_d      = acc_q;
    width_d    = width_q;
    col_d      = col_q;
    row_d      = row_q;
    bip_d      = bip_q;
    held_d     = held_q;
    bnd.data     = '0;
    bnd.count    = 3'd0;
    bnd.has_byte = 1'b1;

    if (phase_q != PH_STOPPED) begin
      if (eos_i) begin
        status_d = ST_EARLY_END;
        phase_d  = PH_STOPPED;
      end else if (phase_q == PH_PIXELS) begin
        case (bip_q)
          2'd0: begin
            held_d[15:8] = byte_i;
            bip_d        = 2'd1;
          end
          2'd1: begin
            held_d[7:0] = byte_i;
            bip_d       = 2'd2;
          end
          default: begin
            bnd.data  = {8'h00, held_q[15:8], held_q[7:0], byte_i};
            bnd.count = 3'd4;
            bip_d     = 2'd0;
            if (col_q == DIM_ONE) begin
              if (row_q == DIM_ONE) begin
                status_d = ST_DONE;
                phase_d  = PH_STOPPED;
              end else begin
                row_d = row_q - DIM_ONE;
                col_d = width_q;
              end
            end else begin
              col_d = col_q - DIM_ONE;
            end
          end
        endcase
      end else if (cmt_q) begin
        if (is_eol(byte_i)) cmt_d = 1'b0;
      end else if (!(skip_q && is_space(byte_i))) begin
        skip_d = 1'b0;
        if ((tok_q == 2'd0) && (byte_i == CH_HASH)) begin
          cmt_d = 1'b1;
        end else if (is_space(byte_i)) begin
          // token ends
          if (tok_q == 2'd0) begin
            status_d = ST_EMPTY_TOK;
            phase_d  = PH_STOPPED;
          end else begin
            case (phase_q)
              PH_MAGIC: begin
                if (!magic_ok_q || (tok_q != 2'd2)) begin
                  status_d = ST_BAD_MAGIC;
                  phase_d  = PH_STOPPED;
                end else begin
                  bnd.data  = {CH_X, CH_R, CH_G, CH_B};
                  bnd.count = 3'd4;
                  phase_d   = PH_WIDTH;
                end
              end
              PH_WIDTH: begin
                if (!positive) begin
                  status_d = ST_BAD_WIDTH;
                  phase_d  = PH_STOPPED;
                end else begin
                  width_d   = acc_q;
                  bnd.data  = {16'h0000, acc_q[7:0], acc_q[15:8]};
                  bnd.count = 3'd2;
                  phase_d   = PH_HEIGHT;
                end
              end
              PH_HEIGHT: begin
                if (!positive) begin
                  status_d = ST_BAD_HEIGHT;
                  phase_d  = PH_STOPPED;
                end else begin
                  col_d     = width_q;
                  row_d     = acc_q;
                  bnd.data  = {16'h0000, acc_q[7:0], acc_q[15:8]};
                  bnd.count = 3'd2;
                  phase_d   = PH_MAXVAL;
                end
              end
              default: begin
                if (neg_q || (acc_q != MAXVAL_REQ)) begin
                  status_d = ST_BAD_MAXVAL;
                  phase_d  = PH_STOPPED;
                end else begin
                  phase_d = PH_PIXELS;
                  bip_d   = 2'd0;
                end
              end
            endcase
            if (phase_d != PH_STOPPED) begin
              tok_d      = 2'd0;
              magic_ok_d = 1'b1;
              neg_d      = 1'b0;
              stop_d     = 1'b0;
              acc_d      = '0;
              cmt_d      = 1'b0;
              skip_d     = (phase_d != PH_PIXELS);
            end
          end
        end else begin
          if (phase_q == PH_MAGIC) begin
            if (((tok_q == 2'd0) && (byte_i != CH_P)) ||
                ((tok_q == 2'd1) && (byte_i != CH_6)) || (tok_q[1] == 1'b1)) begin
              magic_ok_d = 1'b0;
            end
          end else if ((tok_q == 2'd0) && ((byte_i == CH_PLUS) || (byte_i == CH_MINUS))) begin
            neg_d = (byte_i == CH_MINUS);
          end else if (!stop_q && (byte_i >= CH_0) && (byte_i <= CH_9)) begin
            acc_d = (|acc_mul[DIM_BITS+3:DIM_BITS]) ? DIM_MAX : acc_mul[DIM_BITS-1:0];
          end else begin
            stop_d = 1'b1;
          end
          if (tok_q != 2'd3) tok_d = tok_q + 2'd1;
        end
      end
    end

    // status change without bytes: one status-only result
    if ((bnd.count == 3'd0) && (status_d != status_q)) begin
      bnd.count    = 3'd1;
      bnd.has_byte = 1'b0;
    end
    bnd.status = status_d;
    bundle_o   = bnd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_MAGIC;
      status_q   <= ST_BUSY;
      cmt_q      <= 1'b0;
      skip_q     <= 1'b0;
      tok_q      <= 2'd0;
      magic_ok_q <= 1'b1;
      neg_q      <= 1'b0;
      stop_q     <= 1'b0;
      acc_q      <= '0;
      bip_q      <= 2'd0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      status_q   <= status_d;
      cmt_q      <= cmt_d;
      skip_q     <= skip_d;
      tok_q      <= tok_d;
      magic_ok_q <= magic_ok_d;
      neg_q      <= neg_d;
      stop_q     <= stop_d;
      acc_q      <= acc_d;
      bip_q      <= bip_d;
    end
  end

  // dimension and pixel payload, written before use
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      width_q <= width_d;
      col_q   <= col_d;
      row_q   <= row_d;
      held_q  <= held_d;
    end
  end

endmodule

[rtl/core/ppm_p6_to_bgrx_stream_converter_top.sv]
// Top level of the PPM P6 to BGRX stream converter.
// Depends on ppmc_pkg, ppmc_if (ppmc_in_if, ppmc_out_if) and ppmc_parser.

// Takes a binary PPM (P6) stream one byte per request on in_i and sends BGRX
// on out_o, one result per request. The magic "P6" yields 'B','G','R','X';
// width and height yield their low 16 bits big-endian; maxval must be 255;
// each RGB pixel yields B,G,R,0. Errors and the early end of the stream yield
// one status-only result (has_byte 0). last_of_run marks the final result
// caused by an input byte. After the first non-busy status every further
// input, end_of_stream too, is taken and dropped without a result.
// Timing: an input byte is registered, then parsed into a bundle register
// that holds all of its results (at most four). With the bundle register free,
// the first result is valid once the byte has passed the input register and
// the bundle register. A byte waits in the input register while the bundle
// of an earlier byte drains, even if it yields no result itself. Header bytes
// without results run at one per cycle while no earlier bundle drains. At full
// output rate a pixel's B,G,R,0 results drain one after another while the red
// byte of the next pixel waits; it is parsed as the last of them is taken, then
// the green and blue bytes are parsed in turn, the blue one loading the bundle.
// in_i.ready depends combinationally on out_o.ready through the bundle drain.
module ppm_p6_to_bgrx_stream_converter_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  ppmc_in_if.sink           in_i,
  ppmc_out_if.source        out_o
);
  import ppmc_pkg::*;

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_eos_q;

  // result bundle register and read pointer
  logic       bvld_q;
  bundle_t    bundle_q;
  logic [1:0] idx_q;

  bundle_t    bundle_new;
  logic       in_fire;
  logic       out_fire;
  logic       out_last;
  logic       bnd_free;
  logic       step;

  assign out_last = ({1'b0, idx_q} + 3'd1) == bundle_q.count;
  assign out_fire = bvld_q && out_o.ready;
  // bundle register can take the next bundle this cycle
  assign bnd_free = !bvld_q || (out_fire && out_last);
  assign step     = in_vld_q && bnd_free;

  assign in_i.ready = !in_vld_q || step;
  assign in_fire    = in_i.valid && in_i.ready;

  ppmc_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .byte_i   (in_byte_q),
    .eos_i    (in_eos_q),
    .bundle_o (bundle_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_fire) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= in_i.in_byte;
      in_eos_q  <= in_i.end_of_stream;
    end
  end

  // bundles with no results are dropped here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvld_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (step && (bundle_new.count != 3'd0)) begin
      bvld_q <= 1'b1;
      idx_q  <= 2'd0;
    end else if (out_fire && out_last) begin
      bvld_q <= 1'b0;
    end else if (out_fire) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && (bundle_new.count != 3'd0)) begin
      bundle_q <= bundle_new;
    end
  end

  assign out_o.valid       = bvld_q;
  assign out_o.out_byte    = bundle_q.data[idx_q];
  assign out_o.has_byte    = bundle_q.has_byte;
  assign out_o.last_of_run = out_last;
  assign out_o.status      = bundle_q.status;

endmodule

[rtl/core/ppmc_checker.sv]
// Port-level checker for the PPM P6 to BGRX converter, bound to the top level.
// Depends on ppmc_pkg and ppm_p6_to_bgrx_stream_converter_top.
module ppmc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_has_byte_i,
  input logic       out_last_i,
  input logic [2:0] out_status_i
);
  import ppmc_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
      $stable(out_has_byte_i) && $stable(out_last_i) && $stable(out_status_i))
    else $error("result changed while stalled");

  // nothing follows the final result
  a_quiet_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_last_i && (out_status_i != ST_BUSY) |=> !out_valid_i)
    else $error("result after final status");

  // status-only results close their run and carry a final status
  a_status_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_has_byte_i |-> out_last_i && (out_status_i != ST_BUSY))
    else $error("bad status-only result");

  // data bytes never carry an error code
  a_byte_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_has_byte_i |-> (out_status_i == ST_BUSY) || (out_status_i == ST_DONE))
    else $error("data byte with error status");

endmodule

bind ppm_p6_to_bgrx_stream_converter_top ppmc_checker u_ppmc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_byte_i     (out_o.out_byte),
  .out_has_byte_i (out_o.has_byte),
  .out_last_i     (out_o.last_of_run),
  .out_status_i   (out_o.status)
);
